// File: src/tbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types and codes for the tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int CTR_W = 2;

  localparam logic       OP_PREDICT    = 1'b0;
  localparam logic       OP_RESOLVE    = 1'b1;
  localparam logic [1:0] KIND_DIRECT   = 2'd0;
  localparam logic [1:0] KIND_COND     = 2'd1;
  localparam logic [1:0] KIND_INDIRECT = 2'd2;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  typedef struct packed {
    logic [CTR_W-1:0] local_ctr;
    logic [CTR_W-1:0] global_ctr;
    logic [CTR_W-1:0] choice_ctr;
  } ctr_entry_t;

endpackage

// File: src/tbp_hist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_hist_mem
// Local history table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tbp_hist_mem #(
  parameter int IDX_W = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [IDX_W-1:0] wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output logic [IDX_W-1:0] rdata
);

  logic [IDX_W-1:0] mem [2**IDX_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/tbp_ctr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_ctr_mem
// Counter table: local, global and choice counters per entry.
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module tbp_ctr_mem #(
  parameter int IDX_W = 10
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  tbp_pkg::ctr_entry_t wdata,
  input  logic                re,
  input  logic [IDX_W-1:0]    raddr_a,
  input  logic [IDX_W-1:0]    raddr_b,
  output tbp_pkg::ctr_entry_t rdata_a,
  output tbp_pkg::ctr_entry_t rdata_b
);
  import tbp_pkg::*;

  ctr_entry_t mem [2**IDX_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: src/tournament_branch_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// Local/global tournament predictor with a choice table.
//
// Channel  Dir  Signals                       Contents
// s        in   s_tvalid s_tready s_tdata     pc, target, seq_pc,
//               s_tuser                       taken / op, kind
// m        out  m_tvalid m_tready m_tdata     predicted_pc, predicted_taken
//
// Each word passes through the history read, then the dependent counter read,
// then for a conditional resolve a second write (S_WR2) on the single
// counter-table write port.
// After reset a clearing pass over all 2**HIST_LEN entries holds s_tready low.
// A predict result waits in the output register; a following predict holds
// in its last cycle until that register is free.
// ----------------------------------------------------------------------------
module tournament_branch_predictor #(
  parameter int HIST_LEN = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // pc, target, seq_pc, taken
  input  logic [2:0]   s_tuser,   // op, kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata    // predicted_pc, predicted_taken
);
  import tbp_pkg::*;

  localparam int HB = HIST_LEN;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD1   = 3'd2;
  localparam logic [2:0] S_RD2   = 3'd3;
  localparam logic [2:0] S_HOLD  = 3'd4;
  localparam logic [2:0] S_WR2   = 3'd5;

  localparam logic [CTR_W-1:0] CTR_INIT = CTR_W'(2);
  localparam logic [CTR_W-1:0] CTR_MAX  = CTR_W'(3);
  localparam logic [CTR_W-1:0] CTR_MIN  = CTR_W'(0);

  function automatic logic [CTR_W-1:0] ctr_step(input logic [CTR_W-1:0] c,
                                                input logic up);
    logic [CTR_W-1:0] r;
    r = c;
    if (up && c != CTR_MAX) begin
      r = c + CTR_W'(1);
    end else if (!up && c != CTR_MIN) begin
      r = c - CTR_W'(1);
    end
    return r;
  endfunction

  logic [2:0]    state, state_next;
  logic [HB-1:0] clr_idx;
  logic [HB-1:0] gh;
  logic          op_q;
  logic [1:0]    kind_q;
  logic [HB-1:0] slot_q;
  logic [31:0]   tgt_q;
  logic [31:0]   ft_q;
  logic          taken_q;
  logic [HB-1:0] wr2_addr;
  ctr_entry_t    wr2_entry;
  logic [31:0]   out_pc;
  logic          out_taken;

  logic          accept;
  logic          out_free;
  logic          out_load;
  logic [HB-1:0] in_slot;
  logic [31:0]   in_pc;

  logic          hist_we;
  logic [HB-1:0] hist_waddr;
  logic [HB-1:0] hist_wdata;
  logic [HB-1:0] lh;

  logic          ctr_we;
  logic          ctr_re;
  logic [HB-1:0] ctr_waddr;
  ctr_entry_t    ctr_wdata;
  ctr_entry_t    ent_a;
  ctr_entry_t    ent_b;

  logic          local_dir;
  logic          global_dir;
  logic          dir;
  logic [31:0]   pred_pc;
  logic          pred_taken;
  logic          res_cond;
  logic [CTR_W-1:0] new_local;
  ctr_entry_t    ent_a_w;
  ctr_entry_t    ent_b_w;
  logic [HB:0]   lh_shift;
  logic [HB:0]   gh_shift;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign in_pc    = s_tdata[31:0];
  assign in_slot  = HB'(in_pc ^ (in_pc >> 4));

  assign local_dir  = ent_a.local_ctr[CTR_W-1];
  assign global_dir = ent_b.global_ctr[CTR_W-1];
  assign dir        = ent_b.choice_ctr[CTR_W-1] ? local_dir : global_dir;
  assign res_cond   = (op_q == OP_RESOLVE) && (kind_q == KIND_COND);
  assign new_local  = ctr_step(ent_a.local_ctr, taken_q);
  assign lh_shift   = {lh, taken_q};
  assign gh_shift   = {gh, taken_q};

  always_comb begin
    if (kind_q == KIND_DIRECT) begin
      pred_pc    = tgt_q;
      pred_taken = 1'b1;
    end else if (kind_q == KIND_COND) begin
      pred_pc    = dir ? tgt_q : ft_q;
      pred_taken = dir;
    end else begin
      pred_pc    = ft_q;
      pred_taken = 1'b0;
    end
  end

  always_comb begin
    ent_a_w           = ent_a;
    ent_a_w.local_ctr = new_local;
    ent_b_w            = ent_b;
    ent_b_w.local_ctr  = (lh == gh) ? new_local : ent_b.local_ctr;
    ent_b_w.global_ctr = ctr_step(ent_b.global_ctr, taken_q);
    if (local_dir != global_dir) begin
      ent_b_w.choice_ctr = ctr_step(ent_b.choice_ctr, local_dir == taken_q);
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == {HB{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_RD1;
        end
      end
      S_RD1: state_next = S_RD2;
      S_RD2, S_HOLD: begin
        if (op_q == OP_PREDICT) begin
          if (out_free) begin
            out_load   = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_HOLD;
          end
        end else if (res_cond) begin
          state_next = S_WR2;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WR2:   state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = slot_q;
    hist_wdata = lh_shift[HB-1:0];
    ctr_we     = 1'b0;
    ctr_waddr  = lh;
    ctr_wdata  = ent_a_w;
    if (state == S_CLEAR) begin
      hist_we    = 1'b1;
      hist_waddr = clr_idx;
      hist_wdata = '0;
      ctr_we     = 1'b1;
      ctr_waddr  = clr_idx;
      ctr_wdata  = '{local_ctr: CTR_INIT, global_ctr: CTR_INIT, choice_ctr: CTR_INIT};
    end else if (state == S_RD2 && res_cond) begin
      hist_we = 1'b1;
      ctr_we  = 1'b1;
    end else if (state == S_WR2) begin
      ctr_we    = 1'b1;
      ctr_waddr = wr2_addr;
      ctr_wdata = wr2_entry;
    end
  end

  assign ctr_re = (state == S_RD1);

  tbp_hist_mem #(.IDX_W(HB)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (accept),
    .raddr (in_slot),
    .rdata (lh)
  );

  tbp_ctr_mem #(.IDX_W(HB)) u_ctr (
    .clk     (clk),
    .we      (ctr_we),
    .waddr   (ctr_waddr),
    .wdata   (ctr_wdata),
    .re      (ctr_re),
    .raddr_a (lh),
    .raddr_b (gh),
    .rdata_a (ent_a),
    .rdata_b (ent_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      gh       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + HB'(1);
      end
      if (state == S_RD2 && res_cond) begin
        gh <= gh_shift[HB-1:0];
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= s_tuser[0];
      kind_q  <= s_tuser[2:1];
      slot_q  <= in_slot;
      tgt_q   <= s_tdata[63:32];
      ft_q    <= s_tdata[95:64];
      taken_q <= s_tdata[96];
    end
    if (state == S_RD2) begin
      wr2_addr  <= gh;
      wr2_entry <= ent_b_w;
    end
    if (out_load) begin
      out_pc    <= pred_pc;
      out_taken <= pred_taken;
    end
  end

  assign m_tdata = {7'd0, out_taken, out_pc};

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ctr_we && ctr_re))
    else $error("counter table read and write in the same cycle");

  a_wr2_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD2 && res_cond) |=> (state == S_WR2))
    else $error("second counter write missing after conditional resolve");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_RD2 || state == S_HOLD))
    else $error("result appeared outside a predict completion");

  a_gh_update: assert property (@(posedge clk) disable iff (rst)
    !$stable(gh) |-> $past(state == S_RD2 && res_cond))
    else $error("global history changed without a conditional resolve");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready ##1 !s_tready)
    else $error("word accepted before the previous one finished");
`endif

endmodule

// File: tb/tb_tournament_branch_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tournament_branch_predictor
// Drives predict and resolve words into the tournament predictor. It keeps its
// own copy of the history and counter tables and checks every prediction.
// Jump kinds, counter saturation, loop-shaped branch streams and random words
// run with random idling on both streams; a back-to-back run has none.
// ----------------------------------------------------------------------------
module tb_tournament_branch_predictor;
  import tbp_pkg::*;

  localparam int HB = 10;
  localparam int TBL = 1 << HB;

  typedef struct {
    logic        op;
    logic [1:0]  kind;
    logic [31:0] pc;
    logic [31:0] tgt;
    logic [31:0] ft;
    logic        tk;
  } branch_word_t;

  typedef struct {
    logic [31:0] npc;
    logic        tk;
  } prediction_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;   // pc, target, seq_pc, taken
  logic [2:0]   s_tuser = '0;   // op, kind
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;        // predicted_pc, predicted_taken

  logic [HB-1:0] lhist_tbl  [TBL];
  logic [1:0]    local_ctr  [TBL];
  logic [1:0]    global_ctr [TBL];
  logic [1:0]    choice_ctr [TBL];
  logic [HB-1:0] global_hist;

  prediction_t expected_preds[$];
  int          errors = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int          recv_stall = 0;

  tournament_branch_predictor #(.HIST_LEN(HB)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic logic [1:0] sat_step(logic [1:0] c, logic up);
    if (up) begin
      return (c == 2'd3) ? c : c + 2'd1;
    end
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  task automatic clear_tables();
    for (int i = 0; i < TBL; i++) begin
      lhist_tbl[i]  = '0;
      local_ctr[i]  = 2'd2;
      global_ctr[i] = 2'd2;
      choice_ctr[i] = 2'd2;
    end
    global_hist = '0;
  endtask

  // predict pushes an expected result; conditional resolve trains the tables
  task automatic predict_and_train(branch_word_t w);
    logic [HB-1:0] slot;
    logic [HB-1:0] lh;
    logic [HB-1:0] gh;
    logic          ldir;
    logic          gdir;
    logic          dir;
    prediction_t   p;
    slot = HB'(w.pc ^ (w.pc >> 4));
    lh   = lhist_tbl[slot];
    gh   = global_hist;
    ldir = local_ctr[lh] >= 2'd2;
    gdir = global_ctr[gh] >= 2'd2;
    if (w.op == OP_PREDICT) begin
      case (w.kind)
        KIND_DIRECT: begin
          p.npc = w.tgt;
          p.tk  = 1'b1;
        end
        KIND_COND: begin
          dir   = (choice_ctr[gh] >= 2'd2) ? ldir : gdir;
          p.npc = dir ? w.tgt : w.ft;
          p.tk  = dir;
        end
        default: begin
          p.npc = w.ft;
          p.tk  = 1'b0;
        end
      endcase
      expected_preds.push_back(p);
    end else if (w.kind == KIND_COND) begin
      local_ctr[lh]  = sat_step(local_ctr[lh], w.tk);
      global_ctr[gh] = sat_step(global_ctr[gh], w.tk);
      if (ldir != gdir) begin
        choice_ctr[gh] = sat_step(choice_ctr[gh], ldir == w.tk);
      end
      lhist_tbl[slot] = {lh[HB-2:0], w.tk};
      global_hist     = {gh[HB-2:0], w.tk};
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic send_word(branch_word_t w);
    int gap;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, w.tk, w.ft, w.tgt, w.pc};
    s_tuser  <= {w.kind, w.op};
    do @(posedge clk); while (!s_tready);
    predict_and_train(w);
  endtask

  function automatic branch_word_t make_word(logic op, logic [1:0] kind, logic [31:0] pc,
                                             logic [31:0] tgt, logic [31:0] ft, logic tk);
    branch_word_t w;
    w.op = op; w.kind = kind; w.pc = pc; w.tgt = tgt; w.ft = ft; w.tk = tk;
    return w;
  endfunction

  function automatic branch_word_t random_word();
    return make_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                     $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
  endfunction

  // predict then resolve one conditional branch
  task automatic run_branch(logic [31:0] pc, logic [31:0] tgt, logic tk);
    send_word(make_word(OP_PREDICT, KIND_COND, pc, tgt, pc + 32'd4,
                        1'($urandom_range(0, 1))));
    send_word(make_word(OP_RESOLVE, KIND_COND, pc, tgt, pc + 32'd4, tk));
  endtask

  task automatic test_jump_kinds();
    send_word(make_word(OP_PREDICT, KIND_DIRECT, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0));
    send_word(make_word(OP_PREDICT, KIND_DIRECT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1));
    send_word(make_word(OP_PREDICT, KIND_INDIRECT, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1));
    send_word(make_word(OP_PREDICT, KIND_INDIRECT, 32'hFFFF_FFFF, 32'h0,
                        32'hFFFF_FFFF, 1'b0));
    send_word(make_word(OP_PREDICT, KIND_UNUSED, 32'h1234_5678, 32'hAAAA_AAAA,
                        32'h5555_5555, 1'b1));
    send_word(make_word(OP_PREDICT, KIND_COND, 32'hFFFF_FFFF, 32'h8000_0000,
                        32'h0000_0001, 1'b0));
    // resolves of non-conditional kinds leave the tables untouched
    send_word(make_word(OP_RESOLVE, KIND_DIRECT, 32'h0, 32'h1, 32'h2, 1'b1));
    send_word(make_word(OP_RESOLVE, KIND_INDIRECT, 32'h0, 32'h1, 32'h2, 1'b0));
    send_word(make_word(OP_RESOLVE, KIND_UNUSED, 32'h0, 32'h1, 32'h2, 1'b1));
    send_word(make_word(OP_PREDICT, KIND_COND, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1));
  endtask

  task automatic test_counter_limits();
    for (int i = 0; i < 5; i++) run_branch(32'h0000_0100, 32'h0000_0800, 1'b1);
    for (int i = 0; i < 6; i++) run_branch(32'h0000_0100, 32'h0000_0800, 1'b0);
    send_word(make_word(OP_PREDICT, KIND_COND, 32'h0000_0100, 32'h0000_0800,
                        32'h0000_0104, 1'b0));
  endtask

  // loop-shaped and correlated branches over a small set of addresses
  task automatic test_loop_branches(int n_words);
    logic [31:0] site_pc [8];
    logic [31:0] site_tgt [8];
    int          period [8];
    int          iter [8];
    int          sent;
    int          s;
    logic        tk;
    sent = 0;
    for (int i = 0; i < 8; i++) begin
      site_pc[i]  = $urandom;
      site_tgt[i] = $urandom;
      period[i]   = $urandom_range(1, 7);
      iter[i]     = 0;
    end
    while (sent < n_words) begin
      s = $urandom_range(0, 7);
      case ($urandom_range(0, 9))
        0: begin
          send_word(make_word(OP_PREDICT, 2'($urandom_range(0, 3)) == KIND_COND ?
                    KIND_DIRECT : KIND_INDIRECT, site_pc[s], site_tgt[s], $urandom, 1'b0));
          sent++;
        end
        1: begin
          send_word(random_word());
          sent++;
        end
        default: begin
          tk = (period[s] == 1) ? s[0] : (iter[s] % period[s] != period[s] - 1);
          if ($urandom_range(0, 15) == 0) tk = ~tk;
          iter[s]++;
          run_branch(site_pc[s], site_tgt[s], tk);
          sent += 2;
        end
      endcase
    end
  endtask

  task automatic test_random_words(int n_words);
    for (int i = 0; i < n_words; i++) send_word(random_word());
  endtask

  task automatic test_back_to_back(int n_words);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_loop_branches(n_words);
  endtask

  always @(negedge clk) begin
    if (recv_idle && recv_stall > 0) begin
      m_tready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if (recv_idle && $urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      recv_stall <= $urandom_range(0, 10);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    prediction_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_preds.size() == 0) begin
        report_mismatch("unexpected word", m_tdata[31:0], 32'h0);
      end else begin
        want = expected_preds.pop_front();
        if (m_tdata[31:0] !== want.npc) begin
          report_mismatch("predicted_pc", m_tdata[31:0], want.npc);
        end
        if (m_tdata[32] !== want.tk) begin
          report_mismatch("predicted_taken", {31'b0, m_tdata[32]}, {31'b0, want.tk});
        end
      end
    end
  end

  initial begin
    clear_tables();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_jump_kinds();
    test_counter_limits();
    test_loop_branches(900);
    test_random_words(400);
    test_back_to_back(300);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_preds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS tournament_branch_predictor");
    end else begin
      $display("FAIL tournament_branch_predictor");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL tournament_branch_predictor");
    $finish;
  end

endmodule
